// ----- sv/tfv_pkg.sv -----
// ----------------------------------------------------------------------------
// tfv_pkg
// Types and constants shared by the text field validator modules.
// ----------------------------------------------------------------------------
package tfv_pkg;

	// One byte of the field, as it arrives on the input channel
	typedef struct packed {
		logic       mode;
		logic [7:0] field_byte;
		logic       last;
	} tfv_in_t;

	// Verdict for one field
	typedef struct packed {
		logic       valid_res;
		logic [6:0] text_length;
	} tfv_out_t;

	// Lower bound class of the code point being decoded
	typedef enum logic [1:0] {
		MIN_NONE  = 2'd0,
		MIN_2BYTE = 2'd1,
		MIN_3BYTE = 2'd2,
		MIN_4BYTE = 2'd3
	} tfv_min_class_t;

	// Per-field decoder and check state (length count is kept apart)
	typedef struct packed {
		logic           after_term;
		logic [1:0]     pending;
		logic [20:0]    code_point;
		tfv_min_class_t min_class;
		logic           failed;
	} tfv_state_t;

	localparam tfv_state_t STATE_CLEAR = '{
		after_term: 1'b0,
		pending:    2'd0,
		code_point: 21'd0,
		min_class:  MIN_NONE,
		failed:     1'b0
	};

	// Mode codes
	localparam logic MODE_PHRASE = 1'b0;
	localparam logic MODE_LABEL  = 1'b1;

	// UTF-8 lead byte ranges
	localparam logic [7:0] LEAD2_LO = 8'hc2;
	localparam logic [7:0] LEAD2_HI = 8'hdf;
	localparam logic [7:0] LEAD3_LO = 8'he0;
	localparam logic [7:0] LEAD3_HI = 8'hef;
	localparam logic [7:0] LEAD4_LO = 8'hf0;
	localparam logic [7:0] LEAD4_HI = 8'hf4;

	// Code point bounds
	localparam logic [20:0] CP_MIN2     = 21'h000080;
	localparam logic [20:0] CP_MIN3     = 21'h000800;
	localparam logic [20:0] CP_MIN4     = 21'h010000;
	localparam logic [20:0] CP_SURR_LO  = 21'h00d800;
	localparam logic [20:0] CP_SURR_HI  = 21'h00dfff;
	localparam logic [20:0] CP_MAX      = 21'h10ffff;

	// Character classes
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LOW_A = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z = 8'h7a;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_UNDER = 8'h5f;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	// Configuration register word index
	localparam logic REG_TEXT_LIMIT = 1'b0;

	localparam int unsigned LIMIT_W = 7;

endpackage

// ----- sv/text_field_validator.sv -----
// ----------------------------------------------------------------------------
// text_field_validator
// Checks a fixed-size, NUL-terminated, zero-padded text field byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   Field bytes arrive on byte_valid/byte_stall/byte_item, one transaction per
//   byte; the byte with last set closes the field. Exactly one verdict
//   transaction per field leaves on verdict_valid/verdict_stall/verdict_item,
//   carrying pass/fail and the text length (saturating at MAX_TEXT).
//   Throughput is one byte per cycle unless a last byte is held back (below).
//   Each byte is held in an input register while the per-byte check logic
//   updates the field state; the verdict is registered, so a field's verdict
//   comes out of the verdict register after the last byte left the input register.
//   While the receiver stalls, the verdict register holds and bytes that are
//   not last keep flowing; a last byte waits in the input register and the
//   input channel stalls until the verdict register frees up.
//   text_limit (APB word 0, reset 64): the user must write it only while the block is idle; the block does not check.
//   Reset empties both registers and clears the field state; no warm-up time.
// ----------------------------------------------------------------------------
module text_field_validator import tfv_pkg::*; #(
	parameter int unsigned MAX_TEXT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  tfv_in_t     byte_item,
	output logic        verdict_valid,
	input  logic        verdict_stall,
	output tfv_out_t    verdict_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned LEN_W = $clog2(MAX_TEXT + 1);

	tfv_in_t              item_s1;
	logic                 valid_s1;
	tfv_state_t           state_q;
	tfv_state_t           state_next;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     len_next;
	logic [LIMIT_W-1:0]   text_limit_q;
	tfv_out_t             verdict;
	tfv_out_t             verdict_q;
	logic                 verdict_valid_q;
	logic                 advance;

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TEXT_LIMIT) ? {25'd0, text_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_limit_q <= LIMIT_W'(64);
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == REG_TEXT_LIMIT) begin
			text_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// A last byte needs room in the verdict register
	assign advance    = valid_s1 && (!item_s1.last || !verdict_valid_q || !verdict_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall)
			item_s1 <= byte_item;
	end

	tfv_step #(
		.MAX_TEXT(MAX_TEXT)
	) u_step (
		.item       (item_s1),
		.st         (state_q),
		.len        (len_q),
		.text_limit (text_limit_q),
		.st_next    (state_next),
		.len_next   (len_next),
		.verdict    (verdict)
	);

	// Field state: clear after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
			len_q   <= '0;
		end else if (advance) begin
			if (item_s1.last) begin
				state_q <= STATE_CLEAR;
				len_q   <= '0;
			end else begin
				state_q <= state_next;
				len_q   <= len_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (advance && item_s1.last) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last)
			verdict_q <= verdict;
	end

	assign verdict_valid = verdict_valid_q;
	assign verdict_item  = verdict_q;

endmodule

// ----- sv/tfv_step.sv -----
// ----------------------------------------------------------------------------
// tfv_step
// Next-state and verdict logic for one field byte: terminator tracking,
// length count, label character check and strict UTF-8 decoding.
// ----------------------------------------------------------------------------
module tfv_step import tfv_pkg::*; #(
	parameter int unsigned MAX_TEXT = 64,
	localparam int unsigned LEN_W = $clog2(MAX_TEXT + 1)
) (
	input  tfv_in_t              item,
	input  tfv_state_t           st,
	input  logic [LEN_W-1:0]     len,
	input  logic [LIMIT_W-1:0]   text_limit,
	output tfv_state_t           st_next,
	output logic [LEN_W-1:0]     len_next,
	output tfv_out_t             verdict
);

	localparam int unsigned CMP_W = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_TEXT);

	logic [7:0]       c;
	logic [20:0]      cp_shift;
	logic [20:0]      low_bound;
	logic             bad;
	logic             label_ok;
	logic [CMP_W-1:0] len_ext;
	logic [CMP_W-1:0] len_cur_ext;
	logic [CMP_W-1:0] limit_ext;
	logic [CMP_W-1:0] limit_eff;

	assign c        = item.field_byte;
	assign cp_shift = {st.code_point[14:0], c[5:0]};
	assign label_ok = (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ||
		(c >= CHAR_ZERO && c <= CHAR_NINE) || (c == CHAR_UNDER);

	always_comb begin
		unique case (st.min_class)
			MIN_2BYTE: low_bound = CP_MIN2;
			MIN_3BYTE: low_bound = CP_MIN3;
			MIN_4BYTE: low_bound = CP_MIN4;
			default:   low_bound = 21'd0;
		endcase
	end

	assign len_cur_ext = CMP_W'(len);

	always_comb begin
		st_next  = st;
		len_next = len;
		bad      = 1'b0;
		if (st.after_term) begin
			if (c != CHAR_NUL)
				st_next.failed = 1'b1;
		end else if (c == CHAR_NUL) begin
			st_next.after_term = 1'b1;
			if (item.mode == MODE_PHRASE && st.pending != 2'd0)
				st_next.failed = 1'b1;
			st_next.pending = 2'd0;
		end else begin
			// saturate the text length
			if (len_cur_ext < MAX_CMP)
				len_next = len + LEN_W'(1);
			if (st.pending != 2'd0) begin
				if (c[7:6] != 2'b10) begin
					st_next.pending = 2'd0;
					bad = 1'b1;
				end else begin
					st_next.code_point = cp_shift;
					st_next.pending    = st.pending - 2'd1;
					// last continuation: range-check the finished code point
					if (st.pending == 2'd1) begin
						if (cp_shift < low_bound ||
							(cp_shift >= CP_SURR_LO && cp_shift <= CP_SURR_HI) ||
							cp_shift > CP_MAX)
							bad = 1'b1;
					end
				end
			end else if (c[7]) begin
				if (c >= LEAD2_LO && c <= LEAD2_HI) begin
					st_next.code_point = {16'd0, c[4:0]};
					st_next.pending    = 2'd1;
					st_next.min_class  = MIN_2BYTE;
				end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
					st_next.code_point = {17'd0, c[3:0]};
					st_next.pending    = 2'd2;
					st_next.min_class  = MIN_3BYTE;
				end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
					st_next.code_point = {18'd0, c[2:0]};
					st_next.pending    = 2'd3;
					st_next.min_class  = MIN_4BYTE;
				end else begin
					bad = 1'b1;
				end
			end
			if (item.mode == MODE_LABEL) begin
				if (!label_ok)
					st_next.failed = 1'b1;
				if (bad)
					st_next.pending = 2'd0;
			end else begin
				if (c < CHAR_SPACE || bad)
					st_next.failed = 1'b1;
			end
		end
	end

	assign len_ext   = CMP_W'(len_next);
	assign limit_ext = CMP_W'(text_limit);
	assign limit_eff = (limit_ext > MAX_CMP) ? MAX_CMP : limit_ext;

	assign verdict.valid_res = !st_next.failed && st_next.after_term &&
		(len_ext != '0) && (len_ext < limit_eff);
	assign verdict.text_length = len_ext[6:0];

endmodule

// ----- tb/sv/text_field_validator_test.sv -----
// ----------------------------------------------------------------------------
// text_field_validator_test
// Self-checking bench for the text field validator. Fields are fed one byte
// per transaction. A behavioral predictor inside the bench follows every
// accepted byte and queues the verdict that it expects. Each verdict that
// leaves the block is compared field by field with the oldest queued one.
// Directed fields cover both modes, UTF-8 edge cases, framing errors,
// saturation and limit extremes. Randomized fields then run under several
// text limits, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module text_field_validator_test;
	import tfv_pkg::*;

	localparam int unsigned TEXT_MAX    = 64;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam logic [2:0]  LIMIT_ADDR  = {REG_TEXT_LIMIT, 2'b00};

	typedef logic [7:0] byte_q_t[$];

	logic        clk = 1'b0;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	tfv_in_t     byte_item;
	logic        verdict_valid;
	logic        verdict_stall = 1'b0;
	tfv_out_t    verdict_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predictor state for the field in progress
	bit             after_nul;
	int unsigned    text_count;
	logic [1:0]     dec_pending;
	logic [20:0]    dec_cp;
	tfv_min_class_t dec_class;
	bit             field_failed;
	logic [6:0]     limit_cfg = 7'd64;

	tfv_out_t verdict_q[$];

	bit idle_on = 1'b1;
	int error_count;
	int cycle_count;
	int bytes_sent;
	int fields_sent;
	int verdicts_checked;
	int passes_seen;

	text_field_validator #(.MAX_TEXT(TEXT_MAX)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.verdict_valid(verdict_valid),
		.verdict_stall(verdict_stall),
		.verdict_item(verdict_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
				verdict_q.size());
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) verdict_stall <= idle_on && ($urandom_range(99) < 13);

	task automatic report_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	function automatic void clear_field();
		after_nul    = 1'b0;
		text_count   = 0;
		dec_pending  = 2'd0;
		dec_cp       = 21'd0;
		dec_class    = MIN_NONE;
		field_failed = 1'b0;
	endfunction

	// Advance the UTF-8 decoder by one text byte; returns 1 on an encoding error
	function automatic logic decode_utf8(input logic [7:0] c);
		logic [20:0] floor_cp;
		if (dec_pending != 2'd0) begin
			if (c[7:6] != 2'b10) begin
				dec_pending = 2'd0;
				return 1'b1;
			end
			dec_cp = {dec_cp[14:0], c[5:0]};
			dec_pending = dec_pending - 2'd1;
			if (dec_pending == 2'd0) begin
				case (dec_class)
					MIN_2BYTE: floor_cp = CP_MIN2;
					MIN_3BYTE: floor_cp = CP_MIN3;
					MIN_4BYTE: floor_cp = CP_MIN4;
					default:   floor_cp = 21'd0;
				endcase
				if (dec_cp < floor_cp || (dec_cp >= CP_SURR_LO && dec_cp <= CP_SURR_HI) ||
					dec_cp > CP_MAX)
					return 1'b1;
			end
			return 1'b0;
		end
		if (!c[7])
			return 1'b0;
		if (c >= LEAD2_LO && c <= LEAD2_HI) begin
			dec_cp      = {16'd0, c[4:0]};
			dec_pending = 2'd1;
			dec_class   = MIN_2BYTE;
		end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
			dec_cp      = {17'd0, c[3:0]};
			dec_pending = 2'd2;
			dec_class   = MIN_3BYTE;
		end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
			dec_cp      = {18'd0, c[2:0]};
			dec_pending = 2'd3;
			dec_class   = MIN_4BYTE;
		end else begin
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Update the field state with one accepted byte; queue a verdict on last
	function automatic void take_byte(input tfv_in_t item);
		logic [7:0]  c;
		logic        bad;
		int unsigned lim;
		tfv_out_t    v;
		c = item.field_byte;
		if (after_nul) begin
			if (c != CHAR_NUL)
				field_failed = 1'b1;
		end else if (c == CHAR_NUL) begin
			after_nul = 1'b1;
			// a sequence cut off by the terminator only counts in phrase mode
			if (item.mode == MODE_PHRASE && dec_pending != 2'd0)
				field_failed = 1'b1;
			dec_pending = 2'd0;
		end else begin
			if (text_count < TEXT_MAX)
				text_count++;
			bad = decode_utf8(c);
			if (item.mode == MODE_LABEL) begin
				if (!((c >= CHAR_LOW_A && c <= CHAR_LOW_Z) ||
					(c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_UNDER))
					field_failed = 1'b1;
				if (bad)
					dec_pending = 2'd0;
			end else if (c < CHAR_SPACE || bad) begin
				field_failed = 1'b1;
			end
		end
		if (item.last) begin
			lim = (limit_cfg > TEXT_MAX) ? TEXT_MAX : limit_cfg;
			v.valid_res   = !field_failed && after_nul && text_count != 0 && text_count < lim;
			v.text_length = text_count[6:0];
			verdict_q.push_back(v);
			clear_field();
		end
	endfunction

	always @(posedge clk) begin : verdict_check
		tfv_out_t want;
		if (arst_n && verdict_valid && !verdict_stall) begin
			verdicts_checked++;
			if (verdict_q.size() == 0) begin
				report_mismatch("verdict with no field outstanding");
			end else begin
				want = verdict_q.pop_front();
				if (verdict_item.valid_res !== want.valid_res)
					report_mismatch($sformatf("verdict %0d: valid_res %b, expected %b",
						verdicts_checked, verdict_item.valid_res, want.valid_res));
				if (verdict_item.text_length !== want.text_length)
					report_mismatch($sformatf("verdict %0d: text_length %0d, expected %0d",
						verdicts_checked, verdict_item.text_length, want.text_length));
				if (verdict_item.valid_res === 1'b1)
					passes_seen++;
			end
		end
	end

	task automatic send_byte(input logic mode, input logic [7:0] b, input logic last);
		tfv_in_t item;
		item = '{mode: mode, field_byte: b, last: last};
		while (idle_on && $urandom_range(99) < 13) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= item;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		take_byte(item);
		bytes_sent++;
		if (last)
			fields_sent++;
	endtask

	task automatic send_field(input logic mode, input byte_q_t q);
		foreach (q[i])
			send_byte(mode, q[i], i == q.size() - 1);
	endtask

	// Hold the input until every queued verdict has come out
	task automatic drain();
		byte_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input logic [6:0] value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= {25'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		// read back through a second transfer
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[LIMIT_W-1:0] !== value)
			report_mismatch($sformatf("text_limit reads %0d, wrote %0d",
				prdata[LIMIT_W-1:0], value));
		psel    <= 1'b0;
		penable <= 1'b0;
		limit_cfg = value;
	endtask

	// One random character: mostly well formed, sometimes overlong, surrogate,
	// out of range, cut short or a raw byte
	function automatic byte_q_t rand_char(input logic mode);
		byte_q_t     q;
		int          r;
		int          cls;
		bit          overlong;
		bit          wild;
		logic [20:0] cp;
		r = $urandom_range(99);
		overlong = r >= 12 && r < 14;
		wild = r >= 8 && r < 12;
		if (r < 8) begin
			q.push_back(8'($urandom_range(255)));
			return q;
		end
		if (mode == MODE_LABEL) begin
			cls = $urandom_range(36);
			if (cls < 26)
				q.push_back(CHAR_LOW_A + 8'(cls));
			else if (cls < 36)
				q.push_back(CHAR_ZERO + 8'(cls - 26));
			else
				q.push_back(CHAR_UNDER);
			return q;
		end
		cls = $urandom_range(3);
		case (cls)
			0: begin
				cp = 21'($urandom_range(32'h20, 32'h7f));
				q.push_back(cp[7:0]);
			end
			1: begin
				cp = overlong ? 21'($urandom_range(32'h7f)) : 21'($urandom_range(32'h80, 32'h7ff));
				q.push_back({3'b110, cp[10:6]});
				q.push_back({2'b10, cp[5:0]});
			end
			2: begin
				cp = overlong ? 21'($urandom_range(32'h7ff)) : 21'($urandom_range(32'h800, 32'hffff));
				if (!wild && cp >= CP_SURR_LO && cp <= CP_SURR_HI)
					cp = cp - 21'h1000;
				q.push_back({4'b1110, cp[15:12]});
				q.push_back({2'b10, cp[11:6]});
				q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				if (overlong)
					cp = 21'($urandom_range(32'hffff));
				else if (wild)
					cp = 21'($urandom_range(32'h10000, 32'h13ffff));
				else
					cp = 21'($urandom_range(32'h10000, 32'h10ffff));
				q.push_back({5'b11110, cp[20:18]});
				q.push_back({2'b10, cp[17:12]});
				q.push_back({2'b10, cp[11:6]});
				q.push_back({2'b10, cp[5:0]});
			end
		endcase
		if (r >= 14 && r < 16 && q.size() > 1)
			void'(q.pop_back());
		return q;
	endfunction

	task automatic random_field();
		byte_q_t q;
		logic    base_mode;
		int      n;
		int      pad;
		int      r;
		base_mode = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 10)
			n = 0;
		else if (r < 80)
			n = $urandom_range(1, 12);
		else if (r < 95)
			n = $urandom_range(13, 63);
		else
			n = $urandom_range(60, 70);
		while (q.size() < n)
			q = {q, rand_char(base_mode)};
		if ($urandom_range(99) >= 4)
			q.push_back(CHAR_NUL);
		pad = $urandom_range(4);
		repeat (pad)
			q.push_back(($urandom_range(99) < 5) ? 8'($urandom_range(1, 255)) : CHAR_NUL);
		if (q.size() == 0)
			q.push_back(CHAR_NUL);
		foreach (q[i])
			send_byte(($urandom_range(99) < 4) ? ~base_mode : base_mode, q[i],
				i == q.size() - 1);
	endtask

	task automatic test_label_mode();
		send_field(MODE_LABEL, '{CHAR_LOW_A, CHAR_LOW_Z, CHAR_ZERO, CHAR_NINE, CHAR_UNDER,
			CHAR_NUL});
		send_field(MODE_LABEL, '{8'h41, CHAR_NUL});
		send_field(MODE_LABEL, '{8'h2d, CHAR_NUL, CHAR_NUL});
		send_field(MODE_LABEL, '{8'hc2, 8'h80, CHAR_NUL});
	endtask

	task automatic test_phrase_mode();
		send_field(MODE_PHRASE, '{CHAR_SPACE, 8'h7f, 8'hc2, 8'h80, 8'hdf, 8'hbf, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'he0, 8'ha0, 8'h80, 8'hef, 8'hbf, 8'hbf, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'hf0, 8'h90, 8'h80, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf,
			CHAR_NUL});
		send_field(MODE_PHRASE, '{8'h1f, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'hc1, 8'hbf, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'he0, 8'h9f, 8'hbf, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'hed, 8'ha0, 8'h80, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'hf0, 8'h8f, 8'hbf, 8'hbf, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'hf4, 8'h90, 8'h80, 8'h80, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'hf5, 8'h80, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'h80, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'hff, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'hc2, 8'h41, CHAR_NUL});
		send_field(MODE_PHRASE, '{8'he2, 8'h82, CHAR_NUL});
	endtask

	task automatic test_framing();
		send_field(MODE_PHRASE, '{CHAR_NUL});
		send_field(MODE_LABEL, '{CHAR_NUL, CHAR_NUL, CHAR_NUL});
		send_field(MODE_LABEL, '{CHAR_LOW_A, CHAR_LOW_Z});
		send_field(MODE_PHRASE, '{CHAR_LOW_A, CHAR_NUL, 8'h01, CHAR_NUL});
		send_field(MODE_LABEL, '{CHAR_LOW_A, CHAR_NUL, 8'hff});
	endtask

	task automatic test_mixed_mode();
		// terminator in label mode does not fail an open sequence
		send_byte(MODE_PHRASE, 8'hc2, 1'b0);
		send_byte(MODE_LABEL, CHAR_NUL, 1'b1);
		// a label byte breaking a sequence resets the decoder
		send_byte(MODE_PHRASE, 8'he2, 1'b0);
		send_byte(MODE_LABEL, CHAR_LOW_A, 1'b0);
		send_byte(MODE_PHRASE, 8'h41, 1'b0);
		send_byte(MODE_PHRASE, CHAR_NUL, 1'b1);
		// sequence started in label mode, completed in phrase mode
		send_byte(MODE_LABEL, 8'hc3, 1'b0);
		send_byte(MODE_PHRASE, 8'ha9, 1'b0);
		send_byte(MODE_PHRASE, CHAR_NUL, 1'b1);
	endtask

	task automatic test_long_text();
		byte_q_t q;
		set_limit(7'd64);
		repeat (63) q.push_back(CHAR_LOW_A);
		q.push_back(CHAR_NUL);
		send_field(MODE_LABEL, q);
		q.delete();
		repeat (64) q.push_back(8'h41);
		q.push_back(CHAR_NUL);
		send_field(MODE_PHRASE, q);
		q.delete();
		repeat (70) q.push_back(CHAR_ZERO);
		q.push_back(CHAR_NUL);
		send_field(MODE_LABEL, q);
		set_limit(7'd127);
		send_field(MODE_LABEL, q);
		q.delete();
		repeat (63) q.push_back(CHAR_UNDER);
		q.push_back(CHAR_NUL);
		send_field(MODE_LABEL, q);
	endtask

	task automatic test_limit_extremes();
		set_limit(7'd1);
		send_field(MODE_LABEL, '{CHAR_LOW_A, CHAR_NUL});
		set_limit(7'd2);
		send_field(MODE_LABEL, '{CHAR_LOW_A, CHAR_NUL});
		send_field(MODE_LABEL, '{CHAR_LOW_A, CHAR_LOW_Z, CHAR_NUL});
		set_limit(7'd0);
		send_field(MODE_PHRASE, '{CHAR_LOW_A, CHAR_NUL});
		set_limit(7'd127);
		send_field(MODE_PHRASE, '{CHAR_LOW_A, CHAR_NUL});
	endtask

	task automatic test_random_fields();
		logic [6:0] limits[7];
		int         budget;
		int         start;
		limits = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd2, 7'($urandom_range(3, 64)),
			7'($urandom_range(1, 64))};
		foreach (limits[p]) begin
			set_limit(limits[p]);
			budget = (limits[p] <= 7'd2) ? 40 : 90;
			start = bytes_sent;
			while (bytes_sent - start < budget)
				random_field();
		end
	endtask

	task automatic test_back_to_back();
		int start;
		set_limit(7'd64);
		idle_on = 1'b0;
		start = bytes_sent;
		while (bytes_sent - start < 150)
			random_field();
		drain();
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n     <= 1'b0;
		byte_valid <= 1'b0;
		byte_item  <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		clear_field();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_label_mode();
		test_phrase_mode();
		test_framing();
		test_mixed_mode();
		drain();
		test_long_text();
		test_limit_extremes();
		test_random_fields();
		test_back_to_back();
		drain();

		$display("sent %0d fields in %0d bytes, both modes, text limits from 0 to 127",
			fields_sent, bytes_sent);
		$display("checked %0d verdicts, %0d accepting, %0d mismatches",
			verdicts_checked, passes_seen, error_count);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- text_field_validator.f -----
sv/tfv_pkg.sv
sv/tfv_step.sv
sv/text_field_validator.sv
tb/sv/text_field_validator_test.sv
